// File: src/bla_pkg.sv
// Shared constants, codes and controller/datapath types of the line assembler.
package bla_pkg;

	localparam int LINE_CAP = 64;
	localparam int IDX_W = $clog2(LINE_CAP);
	localparam int FILL_W = IDX_W + 1;
	localparam int LIM_W = 7;
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(LINE_CAP);

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EOI   = 2'd1,
		KIND_DROP  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} state_t;

	typedef struct packed {
		logic store;
		logic clr_fill;
		logic set_discard;
		logic clr_discard;
		logic set_flag;
		logic clr_flag;
		logic start_emit;
		logic issue;
	} cmd_t;

	typedef struct packed {
		logic is_newline;
		logic discarding;
		logic over;
		logic fits;
		logic fill_zero;
		logic can_issue;
		logic rd_last;
		logic emit_empty;
	} status_t;

endpackage

// File: src/bla_item_if.sv
// Input channel: one stream word per handshake.
interface bla_item_if import bla_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: src/bla_line_if.sv
// Output channel: one line byte, or an empty-line marker, per word.
interface bla_line_if import bla_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       line_empty;
	logic       line_end;
	logic       long_line_seen;

	modport source (output valid, output line_byte, output line_empty, output line_end,
		output long_line_seen, input ready);
	modport sink   (input valid, input line_byte, input line_empty, input line_end,
		input long_line_seen, output ready);
endinterface

// File: src/bla_ctrl.sv
// Controller: decodes accepted words and sequences the read-out of a line.
module bla_ctrl import bla_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  kind_t   in_kind,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		fire     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				fire     = in_valid;
				if (fire) begin
					unique case (in_kind)
						KIND_DATA: begin
							if (sts.is_newline) begin
								cmd.clr_fill = 1'b1;
								priority if (sts.discarding) begin
									cmd.clr_discard = 1'b1;
								end else if (sts.over) begin
									cmd.set_flag = 1'b1;
								end else begin
									cmd.start_emit = 1'b1;
									state_d        = ST_EMIT;
								end
							end else if (!sts.discarding) begin
								if (sts.fits) begin
									cmd.store = 1'b1;
								end else begin
									cmd.set_flag    = 1'b1;
									cmd.set_discard = 1'b1;
									cmd.clr_fill    = 1'b1;
								end
							end
						end
						KIND_EOI: begin
							cmd.clr_fill = 1'b1;
							priority if (sts.discarding) begin
								cmd.clr_discard = 1'b1;
							end else if (!sts.fill_zero) begin
								cmd.start_emit = 1'b1;
								state_d        = ST_EMIT;
							end
						end
						KIND_DROP: begin
							cmd.clr_fill    = 1'b1;
							cmd.clr_discard = 1'b1;
						end
						KIND_CLEAR: begin
							cmd.clr_flag = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				if (sts.can_issue) begin
					cmd.issue = 1'b1;
					if (sts.emit_empty || sts.rd_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: src/bla_dp.sv
// Datapath: line store, fill count, flags, limit register and output pipeline.
module bla_dp import bla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	input  logic [7:0]       in_byte,
	input  cmd_t             cmd,
	output status_t          sts,
	bla_line_if.source       lines
);

	logic [7:0]        mem [LINE_CAP];
	logic [LIM_W-1:0]  limit_q;
	logic [LIM_W-1:0]  lim;
	logic [FILL_W-1:0] fill_q;
	logic              discard_q;
	logic              flag_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic              empty_q;

	// read stage: memory data register plus its tags
	logic [7:0] rd_s1;
	logic       valid_s1;
	logic       empty_s1;
	logic       end_s1;
	logic       flag_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_empty_q;
	logic       out_end_q;
	logic       out_flag_q;

	logic out_take;
	logic out_load;

	always_comb begin
		priority if (limit_q == '0) begin
			lim = LIM_W'(1);
		end else if (limit_q > LIM_W'(LINE_CAP)) begin
			lim = LIM_W'(LINE_CAP);
		end else begin
			lim = limit_q;
		end
	end

	assign out_take = out_valid_q && lines.ready;
	assign out_load = valid_s1 && (!out_valid_q || out_take);

	always_comb begin
		sts.is_newline = (in_byte == NEWLINE_BYTE);
		sts.discarding = discard_q;
		sts.over       = (LIM_W'(fill_q) > lim);
		sts.fits       = (LIM_W'(fill_q) < lim);
		sts.fill_zero  = (fill_q == '0);
		sts.can_issue  = !valid_s1 || out_load;
		sts.rd_last    = (rd_idx_q == last_idx_q);
		sts.emit_empty = empty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= LIMIT_RESET;
			fill_q    <= '0;
			discard_q <= 1'b0;
			flag_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.clr_fill) begin
				fill_q <= '0;
			end else if (cmd.store) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.set_discard) begin
				discard_q <= 1'b1;
			end else if (cmd.clr_discard) begin
				discard_q <= 1'b0;
			end
			if (cmd.set_flag) begin
				flag_q <= 1'b1;
			end else if (cmd.clr_flag) begin
				flag_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[IDX_W-1:0]] <= in_byte;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[rd_idx_q];
		end
	end

	// read-out bookkeeping; the line length is latched as fill clears on the same word
	always_ff @(posedge clk) begin
		if (cmd.start_emit) begin
			rd_idx_q   <= '0;
			last_idx_q <= IDX_W'(fill_q - FILL_W'(1));
			empty_q    <= (fill_q == '0);
		end else if (cmd.issue) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
		if (cmd.issue) begin
			empty_s1 <= empty_q;
			end_s1   <= empty_q || (rd_idx_q == last_idx_q);
			flag_s1  <= flag_q;
		end
		if (out_load) begin
			out_byte_q  <= empty_s1 ? 8'd0 : rd_s1;
			out_empty_q <= empty_s1;
			out_end_q   <= end_s1;
			out_flag_q  <= flag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign lines.valid          = out_valid_q;
	assign lines.line_byte      = out_byte_q;
	assign lines.line_empty     = out_empty_q;
	assign lines.line_end       = out_end_q;
	assign lines.long_line_seen = out_flag_q;

endmodule

// File: src/bounded_line_assembler.sv
// Top level of the bounded line assembler: controller and datapath.
//
//  channel  dir  payload                                        handshake
//  items    in   kind[1:0], data_byte[7:0]                      valid/ready
//  lines    out  line_byte[7:0], line_empty, line_end,          valid/ready
//                long_line_seen
//  cfg      in   cfg_wdata[6:0] (max_line_len)                  cfg_we, no stall
//
// A word that emits nothing leaves the controller idle; ready is high in the next cycle.
// A word that emits a line of n bytes holds off input while the store is read
// out one byte a cycle, when lines.ready does not stall it, through its single
// read port; an empty line is one marker word. Output words pass a read register
// and an output register, so lines.ready low stalls only the read-out. Reset
// clears control state; the line store is not cleared.
module bounded_line_assembler import bla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata,
	bla_item_if.sink         items,
	bla_line_if.source       lines
);

	cmd_t    cmd;
	status_t sts;
	kind_t   in_kind;

	assign in_kind = kind_t'(items.kind);

	bla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_kind  (in_kind),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bla_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_byte   (items.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.lines     (lines)
	);

endmodule
